/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the command overlap matcher RTL.
// Each macro expects signals named clk and arst_n in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/cmdovl_pkg.sv */
// Package for the command overlap matcher: request/result types, the link
// record passed between cells, the command ROM and case folding.
// No dependencies.
`default_nettype none

package cmdovl_pkg;

	localparam int NUM_COMMANDS_DEF    = 12;
	localparam int MAX_COMMAND_LEN_DEF = 6;
	localparam int MASK_W              = 12;
	localparam int ROM_WIDTH           = 16;
	localparam int ROM_TXT_W           = ROM_WIDTH * 8;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
		logic       empty_req;
	} req_t;

	typedef struct packed {
		logic [MASK_W-1:0] match_mask;
		logic              any_match;
	} res_t;

	// Record handed from cell to cell, one per request
	typedef struct packed {
		logic              valid;
		logic [7:0]        ch;      // already case folded
		logic              last;
		logic              empty;
		logic [6:0]        half;    // typed length / 2, meaningful on last
		logic [MASK_W-1:0] mask;
	} link_t;

	// Only A..Z fold to lower case
	function automatic logic [7:0] fold8(logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	// Byte p of command k, zero past the end of the word
	function automatic logic [7:0] rom_char(int k, int p);
		logic [ROM_TXT_W-1:0] txt;
		int                   len;
		logic [7:0]           r;
		txt = '0;
		len = 0;
		r   = 8'h00;
		case (k)
			0: begin txt = ROM_TXT_W'("help");   len = 4; end
			1: begin txt = ROM_TXT_W'("h");      len = 1; end
			2: begin txt = ROM_TXT_W'("find");   len = 4; end
			3: begin txt = ROM_TXT_W'("clear");  len = 5; end
			4: begin txt = ROM_TXT_W'("quit");   len = 4; end
			5: begin txt = ROM_TXT_W'("q");      len = 1; end
			6: begin txt = ROM_TXT_W'("f");      len = 1; end
			7: begin txt = ROM_TXT_W'("total");  len = 5; end
			8: begin txt = ROM_TXT_W'("back");   len = 4; end
			9: begin txt = ROM_TXT_W'("b");      len = 1; end
			10: begin txt = ROM_TXT_W'("author"); len = 6; end
			11: begin txt = ROM_TXT_W'("story");  len = 5; end
			default: begin txt = '0; len = 0; end
		endcase
		if (p >= 0 && p < len) begin
			r = txt[(len - 1 - p) * 8 +: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/command_char_overlap_matcher_unit.sv */
// Command word overlap matcher. Takes one character request per cycle and
// sustains one request per clock unless held; each request travels down a
// chain of one cell per command, and a word's result is loaded into the
// output register as its last request leaves the chain. The chain only holds
// when a result waits on a stalled output and the tail has the next result.
// Matching ignores ASCII case (A..Z only); typed length saturates at 255.
`default_nettype none
`include "assert_macros.svh"

module command_char_overlap_matcher_unit #(
	parameter int NUM_COMMANDS    = cmdovl_pkg::NUM_COMMANDS_DEF,
	parameter int MAX_COMMAND_LEN = cmdovl_pkg::MAX_COMMAND_LEN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             char_valid,
	output logic                  char_stall,
	input  wire cmdovl_pkg::req_t chr,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output cmdovl_pkg::res_t      result
);
	import cmdovl_pkg::*;

	link_t lnk [NUM_COMMANDS+1];
	logic  adv;
	logic  tail_res;
	logic  res_valid_q;
	res_t  res_q;

	// the chain moves unless its tail result would overrun a held result
	assign tail_res = lnk[NUM_COMMANDS].valid && lnk[NUM_COMMANDS].last;
	assign adv      = !(res_valid_q && result_stall && tail_res);

	cmdovl_head u_head (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.chr        (chr),
		.lnk_out    (lnk[0])
	);

	for (genvar k = 0; k < NUM_COMMANDS; k++) begin : g_cell
		cmdovl_cell #(
			.IDX             (k),
			.MAX_COMMAND_LEN (MAX_COMMAND_LEN)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.lnk_in  (lnk[k]),
			.lnk_out (lnk[k+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && tail_res) begin
			res_valid_q      <= 1'b1;
			res_q.match_mask <= lnk[NUM_COMMANDS].mask;
			res_q.any_match  <= (lnk[NUM_COMMANDS].mask != '0);
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	`ASSERT_CLK(a_res_from_last, $rose(result_valid) |-> $past(tail_res), "result raised without a last request at the chain tail")
	`ASSERT_CLK(a_any_consistent, result_valid |-> (result.any_match == (result.match_mask != '0)), "any_match disagrees with match_mask")
	`ASSERT_CLK(a_hold_only_on_block, !adv |-> (result_valid && result_stall), "chain held without a blocked result")

endmodule

`default_nettype wire

/* hw/rtl/cmdovl_head.sv */
// Head of the cell chain: folds the incoming character, keeps the typed
// length and launches one link record per accepted request. Uses cmdovl_pkg.
`default_nettype none

module cmdovl_head (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           char_valid,
	output logic                char_stall,
	input  wire cmdovl_pkg::req_t    chr,
	output cmdovl_pkg::link_t   lnk_out
);
	import cmdovl_pkg::*;

	logic [7:0] len_q;
	logic [7:0] len_nx;
	logic       take;
	link_t      lnk_q;

	assign char_stall = !adv;
	assign take       = char_valid && adv;

	// saturating length including this character
	always_comb begin
		len_nx = len_q;
		if (!chr.empty_req && len_q != 8'hff) begin
			len_nx = len_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			lnk_q.valid <= 1'b0;
		end else if (adv) begin
			lnk_q.valid <= char_valid;
			lnk_q.ch    <= fold8(chr.char_code);
			lnk_q.last  <= chr.last;
			lnk_q.empty <= chr.empty_req;
			lnk_q.half  <= len_nx[7:1];
			lnk_q.mask  <= '0;
			if (take) begin
				len_q <= chr.last ? 8'd0 : len_nx;
			end
		end
	end

	assign lnk_out = lnk_q;

endmodule

`default_nettype wire

/* hw/rtl/cmdovl_cell.sv */
// One matcher cell: holds the claim bits and overlap count of one command,
// updates them from the passing request and forwards the link record.
// Uses cmdovl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cmdovl_cell #(
	parameter int IDX             = 0,
	parameter int MAX_COMMAND_LEN = cmdovl_pkg::MAX_COMMAND_LEN_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire cmdovl_pkg::link_t  lnk_in,
	output cmdovl_pkg::link_t       lnk_out
);
	import cmdovl_pkg::*;

	localparam int CNT_W = $clog2(MAX_COMMAND_LEN + 1);

	logic [MAX_COMMAND_LEN-1:0] claimed_q;
	logic [CNT_W-1:0]           count_q;
	logic [MAX_COMMAND_LEN-1:0] eq;
	logic [MAX_COMMAND_LEN-1:0] pick;
	logic                       claim;
	logic [CNT_W-1:0]           count_nx;
	logic [MASK_W-1:0]          mask_nx;
	link_t                      lnk_nx;
	link_t                      lnk_q;

	// compare against each ROM position of this command
	for (genvar p = 0; p < MAX_COMMAND_LEN; p++) begin : g_pos
		localparam logic [7:0] RC = fold8(rom_char(IDX, p));
		assign eq[p] = (RC != 8'h00) && (lnk_in.ch == RC) && !claimed_q[p];
	end

	// lowest free equal position wins
	assign pick     = eq & ~(eq - MAX_COMMAND_LEN'(1));
	assign claim    = !lnk_in.empty && (eq != '0);
	assign count_nx = count_q + CNT_W'(claim);

	// match bit for this command, only inside the reported mask
	if (IDX < MASK_W) begin : g_bit
		logic hit;
		assign hit = ({{(8 - CNT_W){1'b0}}, count_nx} > {1'b0, lnk_in.half});
		always_comb begin
			mask_nx      = lnk_in.mask;
			mask_nx[IDX] = hit;
		end
	end else begin : g_nobit
		assign mask_nx = lnk_in.mask;
	end

	// record handed on, carrying this command's mask bit
	always_comb begin
		lnk_nx      = lnk_in;
		lnk_nx.mask = mask_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q   <= '0;
			count_q     <= '0;
			lnk_q.valid <= 1'b0;
		end else if (adv) begin
			lnk_q <= lnk_nx;
			if (lnk_in.valid) begin
				if (lnk_in.last) begin
					claimed_q <= '0;
					count_q   <= '0;
				end else if (claim) begin
					claimed_q <= claimed_q | pick;
					count_q   <= count_nx;
				end
			end
		end
	end

	assign lnk_out = lnk_q;

	`ASSERT_CLK(a_count_tracks_claims, $countones(claimed_q) == int'(count_q), "overlap count differs from claimed positions")
	`ASSERT_NEXT(a_clear_after_last, adv && lnk_in.valid && lnk_in.last, claimed_q == '0 && count_q == '0, "cell state not cleared after last request")

endmodule

`default_nettype wire

/* dv/cmdovl_checker.sv */
// Scoreboard for the command overlap matcher: watches the character and result
// channels, predicts each word's match mask and compares the results in order.
// Depends on cmdovl_pkg for the request and result types.
`timescale 1ns / 1ps

module cmdovl_checker
	import cmdovl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic char_valid,
	input  wire logic char_stall,
	input  req_t      chr,
	input  wire logic result_valid,
	input  wire logic result_stall,
	input  res_t      result,
	output int        fail_count,
	output int        pending_cnt,
	output int        checked_cnt,
	output int        matched_cnt
);

	localparam int NCMD    = NUM_COMMANDS_DEF;
	localparam int CMD_LEN = MAX_COMMAND_LEN_DEF;
	localparam int MAX_PRINTS = 40;

	string cmd_words [NCMD] = '{"help", "h", "find", "clear", "quit", "q",
		"f", "total", "back", "b", "author", "story"};

	// per-word overlap state
	logic [CMD_LEN-1:0] claimed [NCMD];
	int unsigned        overlap [NCMD];
	logic [7:0]         word_len;

	res_t expected_masks[$];
	res_t want;

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_PRINTS) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endtask

	task automatic clear_word();
		for (int k = 0; k < NCMD; k++) begin
			claimed[k] = '0;
			overlap[k] = 0;
		end
		word_len = 8'd0;
	endtask

	// each character takes the lowest free equal position of every command
	task automatic claim_char(input logic [7:0] raw);
		logic [7:0] c;
		int         len;
		c = lower_ascii(raw);
		for (int k = 0; k < NCMD; k++) begin
			len = cmd_words[k].len();
			if (len > CMD_LEN) begin
				len = CMD_LEN;
			end
			for (int p = 0; p < len; p++) begin
				if (lower_ascii(cmd_words[k][p]) == c && !claimed[k][p]) begin
					claimed[k][p] = 1'b1;
					overlap[k]++;
					break;
				end
			end
		end
		if (word_len != 8'hff) begin
			word_len++;
		end
	endtask

	// mask of commands overlapping more than half the typed length
	task automatic score_word();
		res_t       r;
		logic [7:0] half;
		r    = '0;
		half = word_len >> 1;
		for (int k = 0; k < NCMD && k < MASK_W; k++) begin
			if (overlap[k] > half) begin
				r.match_mask[k] = 1'b1;
			end
		end
		r.any_match = |r.match_mask;
		expected_masks.push_back(r);
		clear_word();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_word();
			expected_masks.delete();
			fail_count  = 0;
			pending_cnt = 0;
			checked_cnt = 0;
			matched_cnt = 0;
		end else begin
			// result side
			if (result_valid && !result_stall) begin
				if (expected_masks.size() == 0) begin
					report_mismatch($sformatf("result %03h/%0b with no word pending",
						result.match_mask, result.any_match));
				end else begin
					want = expected_masks.pop_front();
					if (result.match_mask !== want.match_mask) begin
						report_mismatch($sformatf("match_mask got %03h expected %03h",
							result.match_mask, want.match_mask));
					end
					if (result.any_match !== want.any_match) begin
						report_mismatch($sformatf("any_match got %0b expected %0b",
							result.any_match, want.any_match));
					end
					checked_cnt++;
					if (want.any_match) begin
						matched_cnt++;
					end
				end
			end
			// request side
			if (char_valid && !char_stall) begin
				if (!chr.empty_req) begin
					claim_char(chr.char_code);
				end
				if (chr.last) begin
					score_word();
				end
			end
			pending_cnt = expected_masks.size();
		end
	end

endmodule

/* dv/tb_top.sv */
// Testbench top for command_char_overlap_matcher_unit: clock, reset, word
// stimulus, output back-pressure and the verdict. Needs cmdovl_pkg, the
// matcher RTL and cmdovl_checker.
`timescale 1ns / 1ps

module tb_top;
	import cmdovl_pkg::*;

	localparam int  NCMD        = NUM_COMMANDS_DEF;
	localparam int  HOLD_CYCLES = 300;
	localparam int  DRAIN_CYCLES = 3 * (NCMD + 2);
	localparam time TIMEOUT_NS  = 5_000_000;

	logic clk = 1'b0;
	logic arst_n;
	logic char_valid;
	logic char_stall;
	req_t chr;
	logic result_valid;
	logic result_stall;
	res_t result;

	int fail_count, pending_cnt, checked_cnt, matched_cnt;

	int src_idle_pct;
	int sink_idle_pct;
	int hold_reqs;
	int hold_done;
	int hold_left;
	int items_sent;
	int words_sent;

	req_t word_q[$];

	string vocab [NCMD] = '{"help", "h", "find", "clear", "quit", "q",
		"f", "total", "back", "b", "author", "story"};

	always #5 clk = ~clk;

	command_char_overlap_matcher_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.chr          (chr),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	cmdovl_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.chr          (chr),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.pending_cnt  (pending_cnt),
		.checked_cnt  (checked_cnt),
		.matched_cnt  (matched_cnt)
	);

	// receiver: random stalls, plus a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left    <= hold_left - 1;
		end else if (hold_reqs != hold_done) begin
			result_stall <= 1'b1;
			hold_done    <= hold_done + 1;
			hold_left    <= HOLD_CYCLES;
		end else begin
			result_stall <= ($urandom_range(99) < sink_idle_pct);
		end
	end

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'h61 + 8'($urandom_range(25));
		if ($urandom_range(1)) begin
			c = c - 8'd32;
		end
		return c;
	endfunction

	task automatic push_char(input logic [7:0] c);
		req_t r;
		r.char_code = c;
		r.last      = 1'b0;
		r.empty_req = 1'b0;
		word_q.push_back(r);
	endtask

	// empty request, its char_code must be ignored
	task automatic push_gap();
		req_t r;
		r.char_code = 8'($urandom_range(255));
		r.last      = 1'b0;
		r.empty_req = 1'b1;
		word_q.push_back(r);
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i]);
		end
	endtask

	task automatic send_req(input req_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			char_valid <= 1'b0;
		end
		@(negedge clk);
		char_valid <= 1'b1;
		chr        <= r;
		@(posedge clk);
		while (char_stall) begin
			@(posedge clk);
		end
		if (!r.empty_req || r.last) begin
			items_sent++;
		end
	endtask

	// mark the final request as last and send the whole word
	task automatic flush_word();
		req_t r;
		if (word_q.size() == 0) begin
			push_gap();
		end
		r      = word_q.pop_back();
		r.last = 1'b1;
		word_q.push_back(r);
		while (word_q.size() > 0) begin
			r = word_q.pop_front();
			send_req(r);
		end
		words_sent++;
	endtask

	// a command word with random case, typos, reordering, trimming or tail
	task automatic build_cmd_word();
		string      w;
		logic [7:0] c;
		int         a, b, n;
		req_t       t;
		w = vocab[$urandom_range(NCMD - 1)];
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if ($urandom_range(9) == 0) begin
				c = rand_letter();
			end else if ($urandom_range(1)) begin
				c = c - 8'd32;
			end
			push_char(c);
			if ($urandom_range(19) == 0) begin
				push_gap();
			end
		end
		if ($urandom_range(3) == 0) begin
			repeat (2) begin
				a = $urandom_range(word_q.size() - 1);
				b = $urandom_range(word_q.size() - 1);
				t = word_q[a];
				word_q[a] = word_q[b];
				word_q[b] = t;
			end
		end
		if ($urandom_range(4) == 0) begin
			n = $urandom_range(word_q.size(), 1);
			while (word_q.size() > n) begin
				void'(word_q.pop_back());
			end
		end
		if ($urandom_range(4) == 0) begin
			repeat ($urandom_range(3, 1)) push_char(rand_letter());
		end
	endtask

	task automatic random_word();
		int sel;
		sel = $urandom_range(99);
		if (sel < 65) begin
			build_cmd_word();
		end else if (sel < 80) begin
			repeat ($urandom_range(8, 1)) push_char(rand_letter());
		end else if (sel < 95) begin
			repeat ($urandom_range(6, 1)) begin
				if ($urandom_range(4) == 0) begin
					push_gap();
				end
				push_char(8'($urandom_range(255)));
			end
		end else begin
			repeat ($urandom_range(2)) push_gap();
		end
		// sometimes the word is closed by a separate empty request
		if ($urandom_range(9) == 0) begin
			push_gap();
		end
		flush_word();
	endtask

	// longer than 255 characters, so the typed length saturates
	task automatic send_long_word();
		repeat (256 + $urandom_range(6)) push_char(rand_letter());
		flush_word();
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("timeout: %0d words sent, %0d results still pending", words_sent,
			pending_cnt);
		$display("FAIL command_char_overlap_matcher_unit");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		char_valid    = 1'b0;
		chr           = '0;
		result_stall  = 1'b0;
		src_idle_pct  = 38;
		sink_idle_pct = 61;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words
		flush_word();                       // empty word
		push_str("help");  flush_word();
		push_str("STORY"); flush_word();    // upper case up to Y
		push_str("q");     flush_word();
		push_char(8'h00);  flush_word();    // zero byte counts but matches nothing
		push_gap();        push_str("b");  flush_word();
		push_char(8'hc8);  push_char(8'h80); flush_word();
		push_str("@[");    flush_word();    // just outside the fold range
		push_str("A");     flush_word();
		push_str("f");     push_gap();     flush_word();
		push_str("tt");    flush_word();    // repeated letter claims two positions

		// phase 1: sender idles less than receiver
		while (items_sent < 450) begin
			random_word();
		end

		// phase 2: swapped idling
		src_idle_pct  = 61;
		sink_idle_pct = 38;
		send_long_word();
		while (items_sent < 900) begin
			random_word();
		end

		// phase 3: no idling; first a long output hold-off to fill the block
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_reqs++;
		repeat (40) begin
			push_char(rand_letter());
			flush_word();
		end
		send_long_word();
		while (items_sent < 1350) begin
			random_word();
		end
		@(negedge clk);
		char_valid <= 1'b0;

		// drain
		while (pending_cnt != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d requests in %0d words; %0d results compared, %0d with a match.",
			items_sent, words_sent, checked_cnt, matched_cnt);
		$display("Mixed case, raw bytes, empty words, saturated lengths and a long hold-off.");
		if (fail_count == 0) begin
			$display("PASS command_char_overlap_matcher_unit");
		end else begin
			$display("FAIL command_char_overlap_matcher_unit");
		end
		$finish;
	end

endmodule

/* command_char_overlap_matcher_unit.f */
+incdir+hw/rtl
hw/rtl/cmdovl_pkg.sv
hw/rtl/cmdovl_head.sv
hw/rtl/cmdovl_cell.sv
hw/rtl/command_char_overlap_matcher_unit.sv
dv/cmdovl_checker.sv
dv/tb_top.sv
